// File: design/fqalu_pkg.sv
// Shared types and opcode constants for the Q24.8 fixed-point ALU.
// No dependencies.
package fqalu_pkg;

   localparam int DATA_W = 32;

   localparam logic [3:0] OP_ADD      = 4'd0;
   localparam logic [3:0] OP_SUB      = 4'd1;
   localparam logic [3:0] OP_MUL      = 4'd2;
   localparam logic [3:0] OP_DIV      = 4'd3;
   localparam logic [3:0] OP_INC      = 4'd4;
   localparam logic [3:0] OP_DEC      = 4'd5;
   localparam logic [3:0] OP_CMP      = 4'd6;
   localparam logic [3:0] OP_MIN      = 4'd7;
   localparam logic [3:0] OP_MAX      = 4'd8;
   localparam logic [3:0] OP_TO_INT   = 4'd9;
   localparam logic [3:0] OP_FROM_INT = 4'd10;

   // Per-transaction side data that rides along the divider stages.
   typedef struct packed {
      logic [3:0]        op;
      logic [DATA_W-1:0] res;       // result of all non-divide operations
      logic              less;
      logic              equal;
      logic              greater;
      logic              dz;        // divide by zero
      logic              neg;       // quotient sign
   } fq_side_type;

endpackage

// File: design/fqalu_front.sv
// Front stage: simple operations, compare flags, 32x32 product, divider setup.
// Depends on fqalu_pkg.
module fqalu_front #(
   parameter int FRAC_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_valid,
   input  logic [3:0]                     in_op,
   input  logic signed [fqalu_pkg::DATA_W-1:0] in_a,
   input  logic signed [fqalu_pkg::DATA_W-1:0] in_b,
   output logic                           out_valid,
   output fqalu_pkg::fq_side_type         out_side,
   output logic signed [2*fqalu_pkg::DATA_W-1:0] out_prod,
   output logic [fqalu_pkg::DATA_W+FRAC_BITS-1:0] out_dvd,
   output logic [fqalu_pkg::DATA_W-1:0]   out_dsr
);
   localparam int DW = fqalu_pkg::DATA_W + FRAC_BITS;
   localparam logic signed [fqalu_pkg::DATA_W-1:0] ROUND =
      fqalu_pkg::DATA_W'((1 << FRAC_BITS) - 1);

   logic                                 valid_ff;
   fqalu_pkg::fq_side_type               side_ff, side_in;
   logic signed [2*fqalu_pkg::DATA_W-1:0] prod_ff, prod_in;
   logic [DW-1:0]                        dvd_ff, dvd_in;
   logic [fqalu_pkg::DATA_W-1:0]         dsr_ff, dsr_in;
   logic [fqalu_pkg::DATA_W-1:0]         abs_a, abs_b;
   logic signed [fqalu_pkg::DATA_W-1:0]  trunc_a;

   always_comb begin
      abs_a   = in_a[fqalu_pkg::DATA_W-1] ? fqalu_pkg::DATA_W'(-in_a) : in_a;
      abs_b   = in_b[fqalu_pkg::DATA_W-1] ? fqalu_pkg::DATA_W'(-in_b) : in_b;
      // bias negatives so the shift truncates toward zero
      trunc_a = (in_a + (in_a[fqalu_pkg::DATA_W-1] ? ROUND : fqalu_pkg::DATA_W'(0)))
                >>> FRAC_BITS;
      prod_in = in_a * in_b;
      dvd_in  = DW'(abs_a) << FRAC_BITS;
      dsr_in  = abs_b;

      side_in.op      = in_op;
      side_in.less    = in_a < in_b;
      side_in.equal   = in_a == in_b;
      side_in.greater = in_a > in_b;
      side_in.dz      = (in_op == fqalu_pkg::OP_DIV) && (in_b == '0);
      side_in.neg     = in_a[fqalu_pkg::DATA_W-1] ^ in_b[fqalu_pkg::DATA_W-1];

      case (in_op)
         fqalu_pkg::OP_ADD:      side_in.res = in_a + in_b;
         fqalu_pkg::OP_SUB:      side_in.res = in_a - in_b;
         fqalu_pkg::OP_INC:      side_in.res = in_a + fqalu_pkg::DATA_W'(1);
         fqalu_pkg::OP_DEC:      side_in.res = in_a - fqalu_pkg::DATA_W'(1);
         fqalu_pkg::OP_MIN:      side_in.res = (in_a < in_b) ? in_a : in_b;
         fqalu_pkg::OP_MAX:      side_in.res = (in_a > in_b) ? in_a : in_b;
         fqalu_pkg::OP_TO_INT:   side_in.res = trunc_a;
         fqalu_pkg::OP_FROM_INT: side_in.res = in_a << FRAC_BITS;
         default:                side_in.res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff <= side_in;
         prod_ff <= prod_in;
         dvd_ff  <= dvd_in;
         dsr_ff  <= dsr_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_prod  = prod_ff;
   assign out_dvd   = dvd_ff;
   assign out_dsr   = dsr_ff;

endmodule

// File: design/fqalu_div_step.sv
// One radix-2 restoring step of the unsigned magnitude divider, registered.
// Depends on fqalu_pkg.
module fqalu_div_step #(
   parameter int FRAC_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   adv,
   input  logic                                   in_valid,
   input  fqalu_pkg::fq_side_type                 in_side,
   input  logic [fqalu_pkg::DATA_W-1:0]           in_rem,
   input  logic [fqalu_pkg::DATA_W+FRAC_BITS-1:0] in_dvd,
   input  logic [fqalu_pkg::DATA_W-1:0]           in_dsr,
   output logic                                   out_valid,
   output fqalu_pkg::fq_side_type                 out_side,
   output logic [fqalu_pkg::DATA_W-1:0]           out_rem,
   output logic [fqalu_pkg::DATA_W+FRAC_BITS-1:0] out_dvd,
   output logic [fqalu_pkg::DATA_W-1:0]           out_dsr
);
   localparam int DW = fqalu_pkg::DATA_W + FRAC_BITS;

   logic                         valid_ff;
   fqalu_pkg::fq_side_type       side_ff;
   logic [fqalu_pkg::DATA_W-1:0] rem_ff, rem_in;
   logic [DW-1:0]                dvd_ff, dvd_in;
   logic [fqalu_pkg::DATA_W-1:0] dsr_ff;
   logic [fqalu_pkg::DATA_W:0]   trial;
   logic [fqalu_pkg::DATA_W+1:0] diff;

   // shift the next dividend bit into the remainder, subtract if it fits,
   // and shift the quotient bit into the vacated dividend LSB
   always_comb begin
      trial  = {in_rem, in_dvd[DW-1]};
      diff   = {1'b0, trial} - {2'b00, in_dsr};
      rem_in = diff[fqalu_pkg::DATA_W+1] ? trial[fqalu_pkg::DATA_W-1:0]
                                         : diff[fqalu_pkg::DATA_W-1:0];
      dvd_in = {in_dvd[DW-2:0], ~diff[fqalu_pkg::DATA_W+1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff <= in_side;
         rem_ff  <= rem_in;
         dvd_ff  <= dvd_in;
         dsr_ff  <= in_dsr;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_rem   = rem_ff;
   assign out_dvd   = dvd_ff;
   assign out_dsr   = dsr_ff;

endmodule

// File: design/fqalu_back.sv
// Output stage: quotient sign fix-up, divide-by-zero override, result register.
// Depends on fqalu_pkg.
module fqalu_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                in_valid,
   input  fqalu_pkg::fq_side_type              in_side,
   input  logic [fqalu_pkg::DATA_W-1:0]        in_quot,
   output logic                                out_valid,
   output logic signed [fqalu_pkg::DATA_W-1:0] out_result,
   output logic                                out_less,
   output logic                                out_equal,
   output logic                                out_greater,
   output logic                                out_dz
);
   logic                                valid_ff;
   logic signed [fqalu_pkg::DATA_W-1:0] result_ff, result_in;
   logic                                less_ff, equal_ff, greater_ff, dz_ff;

   always_comb begin
      if (in_side.op != fqalu_pkg::OP_DIV) begin
         result_in = in_side.res;
      end else if (in_side.dz) begin
         result_in = '0;
      end else begin
         result_in = in_side.neg ? fqalu_pkg::DATA_W'(-in_quot) : in_quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         result_ff  <= result_in;
         less_ff    <= in_side.less;
         equal_ff   <= in_side.equal;
         greater_ff <= in_side.greater;
         dz_ff      <= in_side.dz;
      end
   end

   assign out_valid   = valid_ff;
   assign out_result  = result_ff;
   assign out_less    = less_ff;
   assign out_equal   = equal_ff;
   assign out_greater = greater_ff;
   assign out_dz      = dz_ff;

endmodule

// File: design/fixed_point_q24_8_alu.sv
// Pipeline from an accepted request to its response: input register, front stage,
// one divider stage per dividend bit, output register.
// Throughput: one transaction per cycle unless stalled; divider depth sets latency.
// A stalled response freezes the whole pipeline and holds off new requests.
// Reset (synchronous, active high) clears every stage valid bit.
module fixed_point_q24_8_alu #(
   parameter int FRAC_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [3:0]                          req_op,
   input  logic signed [fqalu_pkg::DATA_W-1:0] req_operand_a,
   input  logic signed [fqalu_pkg::DATA_W-1:0] req_operand_b,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [fqalu_pkg::DATA_W-1:0] rsp_result,
   output logic                                rsp_a_less,
   output logic                                rsp_a_equal,
   output logic                                rsp_a_greater,
   output logic                                rsp_div_by_zero
);
   // Dividend is |a| scaled by 2^FRAC_BITS; one quotient bit per stage.
   localparam int DW = fqalu_pkg::DATA_W + FRAC_BITS;

   // Global advance: every stage moves unless a finished response is held.
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // Input register.
   logic                                s0_valid_ff;
   logic [3:0]                          s0_op_ff;
   logic signed [fqalu_pkg::DATA_W-1:0] s0_a_ff, s0_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_op_ff <= req_op;
         s0_a_ff  <= req_operand_a;
         s0_b_ff  <= req_operand_b;
      end
   end

   // Front stage: simple ops, flags, signed product, divider operands.
   logic                                   fr_valid;
   fqalu_pkg::fq_side_type                 fr_side;
   logic signed [2*fqalu_pkg::DATA_W-1:0]  fr_prod;
   logic [DW-1:0]                          fr_dvd;
   logic [fqalu_pkg::DATA_W-1:0]           fr_dsr;

   fqalu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s0_valid_ff),
      .in_op     (s0_op_ff),
      .in_a      (s0_a_ff),
      .in_b      (s0_b_ff),
      .out_valid (fr_valid),
      .out_side  (fr_side),
      .out_prod  (fr_prod),
      .out_dvd   (fr_dvd),
      .out_dsr   (fr_dsr)
   );

   // Divider chain. The multiply result (product >>> FRAC_BITS, wrapped)
   // is folded into the side data as it enters the first step.
   logic                         dv_valid [0:DW];
   fqalu_pkg::fq_side_type       dv_side  [0:DW];
   logic [fqalu_pkg::DATA_W-1:0] dv_rem   [0:DW];
   logic [DW-1:0]                dv_dvd   [0:DW];
   logic [fqalu_pkg::DATA_W-1:0] dv_dsr   [0:DW];
   fqalu_pkg::fq_side_type       mul_side;

   always_comb begin
      mul_side = fr_side;
      if (fr_side.op == fqalu_pkg::OP_MUL) begin
         mul_side.res = fr_prod[FRAC_BITS+fqalu_pkg::DATA_W-1:FRAC_BITS];
      end
   end

   assign dv_side[0]  = mul_side;
   assign dv_valid[0] = fr_valid;
   assign dv_rem[0]   = '0;
   assign dv_dvd[0]   = fr_dvd;
   assign dv_dsr[0]   = fr_dsr;

   for (genvar i = 0; i < DW; i++) begin : g_div
      fqalu_div_step #(.FRAC_BITS(FRAC_BITS)) u_step (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (dv_valid[i]),
         .in_side   (dv_side[i]),
         .in_rem    (dv_rem[i]),
         .in_dvd    (dv_dvd[i]),
         .in_dsr    (dv_dsr[i]),
         .out_valid (dv_valid[i+1]),
         .out_side  (dv_side[i+1]),
         .out_rem   (dv_rem[i+1]),
         .out_dvd   (dv_dvd[i+1]),
         .out_dsr   (dv_dsr[i+1])
      );
   end

   // Output register; only the low 32 quotient bits survive the wrap.
   fqalu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (dv_valid[DW]),
      .in_side     (dv_side[DW]),
      .in_quot     (dv_dvd[DW][fqalu_pkg::DATA_W-1:0]),
      .out_valid   (rsp_valid),
      .out_result  (rsp_result),
      .out_less    (rsp_a_less),
      .out_equal   (rsp_a_equal),
      .out_greater (rsp_a_greater),
      .out_dz      (rsp_div_by_zero)
   );

endmodule

// File: design/fqalu_checker.sv
// Port-level checker for the fixed-point ALU, bound to the top level.
// Depends only on the top-level ports.
module fqalu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_result,
   input logic        rsp_a_less,
   input logic        rsp_a_equal,
   input logic        rsp_a_greater,
   input logic        rsp_div_by_zero
);

   a_held_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result))
      else $error("stalled response changed");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held response");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_a_less, rsp_a_equal, rsp_a_greater}))
      else $error("compare flags not one-hot");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_by_zero |-> rsp_result == '0)
      else $error("divide by zero with nonzero result");

endmodule

bind fixed_point_q24_8_alu fqalu_checker u_fqalu_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_result      (rsp_result),
   .rsp_a_less      (rsp_a_less),
   .rsp_a_equal     (rsp_a_equal),
   .rsp_a_greater   (rsp_a_greater),
   .rsp_div_by_zero (rsp_div_by_zero)
);

// File: dv/tb_fixed_point_q24_8_alu.sv
// Self-checking testbench for the Q24.8 fixed-point ALU (fixed_point_q24_8_alu).
// Depends on design/fqalu_pkg.sv and design/fixed_point_q24_8_alu.sv.
// Directed corner cases, then random traffic with random idling on both channels.
module tb_fixed_point_q24_8_alu;

   localparam int FRAC_BITS = 8;
   localparam int DATA_W    = fqalu_pkg::DATA_W;
   localparam int LATENCY   = 35 + FRAC_BITS;  // request accept to response
   localparam int N_RANDOM  = 1000;
   localparam int TAIL_LEN  = 150;             // last transactions run with no idling
   localparam int LONG_HOLD = 150;             // long output hold, well past the pipe depth
   localparam int IDLE_MAX  = 4000;            // watchdog: cycles with nothing accepted
   localparam logic [3:0] OP_SPARE_MAX = 4'd15;

   // One request transaction; drain makes the sender wait until all results are back.
   typedef struct {
      logic [3:0]               op;
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      bit                       drain;
   } fq_req_type;

   typedef struct {
      logic signed [DATA_W-1:0] result;
      logic                     less;
      logic                     equal;
      logic                     greater;
      logic                     dz;
   } fq_rsp_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [3:0]               req_op = fqalu_pkg::OP_ADD;
   logic signed [DATA_W-1:0] req_operand_a = '0;
   logic signed [DATA_W-1:0] req_operand_b = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_result;
   logic                     rsp_a_less;
   logic                     rsp_a_equal;
   logic                     rsp_a_greater;
   logic                     rsp_div_by_zero;

   fq_req_type ops_pending[$];   // stimulus not yet offered to the block
   fq_rsp_type results_due[$];   // expected responses, oldest first

   bit req_took = 1'b0;          // request accepted at the last rising edge
   int n_total = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_dz = 0;
   int n_spare = 0;
   int n_errors = 0;
   int idle_cycles = 0;
   int gap_left = 0;
   int stall_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   fixed_point_q24_8_alu #(.FRAC_BITS(FRAC_BITS)) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_operand_a   (req_operand_a),
      .req_operand_b   (req_operand_b),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result      (rsp_result),
      .rsp_a_less      (rsp_a_less),
      .rsp_a_equal     (rsp_a_equal),
      .rsp_a_greater   (rsp_a_greater),
      .rsp_div_by_zero (rsp_div_by_zero)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 0;
   end

   // Fixed-point ALU behavior. All math is done in 64-bit signed and the
   // low 32 bits are kept, which gives the modulo 2^32 wrap.
   function automatic fq_rsp_type calc_alu_result(input logic [3:0] op,
                                                   input logic signed [DATA_W-1:0] a,
                                                   input logic signed [DATA_W-1:0] b);
      longint     sa;
      longint     sb;
      longint     wide;
      fq_rsp_type r;
      sa   = a;                  // sign extends
      sb   = b;
      wide = 0;
      r.dz = 1'b0;
      case (op)
         fqalu_pkg::OP_ADD:      wide = sa + sb;
         fqalu_pkg::OP_SUB:      wide = sa - sb;
         fqalu_pkg::OP_MUL:      wide = (sa * sb) >>> FRAC_BITS;
         fqalu_pkg::OP_DIV: begin
            if (sb == 0) r.dz = 1'b1;
            else wide = (sa * (longint'(1) << FRAC_BITS)) / sb;  // truncates toward zero
         end
         fqalu_pkg::OP_INC:      wide = sa + 1;
         fqalu_pkg::OP_DEC:      wide = sa - 1;
         fqalu_pkg::OP_CMP:      wide = 0;
         fqalu_pkg::OP_MIN:      wide = (sa < sb) ? sa : sb;
         fqalu_pkg::OP_MAX:      wide = (sa > sb) ? sa : sb;
         fqalu_pkg::OP_TO_INT:   wide = sa / (longint'(1) << FRAC_BITS);
         fqalu_pkg::OP_FROM_INT: wide = sa << FRAC_BITS;
         default:                wide = 0;              // spare opcodes
      endcase
      r.result  = wide[DATA_W-1:0];
      r.less    = (sa < sb);
      r.equal   = (sa == sb);
      r.greater = (sa > sb);
      return r;
   endfunction

   task automatic queue_op(input logic [3:0] op, input logic signed [DATA_W-1:0] a,
                           input logic signed [DATA_W-1:0] b, input bit drain = 1'b0);
      fq_req_type t;
      t.op    = op;
      t.a     = a;
      t.b     = b;
      t.drain = drain;
      ops_pending.push_back(t);
   endtask

   // Operand mix: edge values, small magnitudes (meaningful mul/div), full range.
   function automatic logic signed [DATA_W-1:0] pick_operand();
      int v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 7))
               0:       v = 0;
               1:       v = 32'sh7fffffff;
               2:       v = 32'sh80000000;
               3:       v = -1;
               4:       v = 1;
               5:       v = 256;
               6:       v = -256;
               default: v = 128;
            endcase
         end
         1, 2, 3: v = int'($urandom_range(0, 131071)) - 65536;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Sender: presents the next transaction at the falling edge once the
   // current one is accepted. Gaps come in bursts; none in the tail.
   always @(negedge clock) begin
      fq_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (ops_pending.size() == 0) begin
            req_valid <= 1'b0;
         end else if (ops_pending[0].drain && results_due.size() != 0) begin
            req_valid <= 1'b0;   // pause until the pipe has emptied
         end else if (ops_pending.size() > TAIL_LEN && $urandom_range(0, 9) == 0) begin
            gap_left  <= $urandom_range(0, 5);
            req_valid <= 1'b0;
         end else begin
            nxt = ops_pending.pop_front();
            req_valid     <= 1'b1;
            req_op        <= nxt.op;
            req_operand_a <= nxt.a;
            req_operand_b <= nxt.b;
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold once enough results
   // have come so the pipe fills and back-pressures the request side.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && n_checked >= 400) begin
         hold_done <= 1'b1;
         hold_left <= LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (ops_pending.size() > TAIL_LEN && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: predicts on every accepted request, checks every accepted response.
   always @(posedge clock) begin
      fq_rsp_type want;
      req_took <= req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         results_due.push_back(calc_alu_result(req_op, req_operand_a, req_operand_b));
         n_sent++;
         if (req_op == fqalu_pkg::OP_DIV && req_operand_b == 0) n_dz++;
         if (req_op > fqalu_pkg::OP_FROM_INT) n_spare++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            $error("response with no transaction outstanding: result %h", rsp_result);
            n_errors++;
         end else begin
            want = results_due.pop_front();
            n_checked++;
            if (rsp_result !== want.result) begin
               $error("result: expected %h, actual %h", want.result, rsp_result);
               n_errors++;
            end
            if (rsp_a_less !== want.less) begin
               $error("a_less: expected %b, actual %b", want.less, rsp_a_less);
               n_errors++;
            end
            if (rsp_a_equal !== want.equal) begin
               $error("a_equal: expected %b, actual %b", want.equal, rsp_a_equal);
               n_errors++;
            end
            if (rsp_a_greater !== want.greater) begin
               $error("a_greater: expected %b, actual %b", want.greater, rsp_a_greater);
               n_errors++;
            end
            if (rsp_div_by_zero !== want.dz) begin
               $error("div_by_zero: expected %b, actual %b", want.dz, rsp_div_by_zero);
               n_errors++;
            end
         end
      end
   end

   // Watchdog: a hung handshake on either side ends the run.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      fq_req_type t;
      // Directed: wrap edges, every opcode, divide by zero, truncation toward
      // zero on divide and to_int, equal operands, a spare opcode.
      queue_op(fqalu_pkg::OP_ADD, 32'sh7fffffff, 1);
      queue_op(fqalu_pkg::OP_ADD, 32'sh80000000, 32'sh80000000);
      queue_op(fqalu_pkg::OP_SUB, 32'sh80000000, 1);
      queue_op(fqalu_pkg::OP_SUB, 0, 32'sh80000000);
      queue_op(fqalu_pkg::OP_MUL, 32'sh7fffffff, 32'sh7fffffff);
      queue_op(fqalu_pkg::OP_MUL, 32'sh80000000, 32'sh80000000);
      queue_op(fqalu_pkg::OP_MUL, -256, 256);
      queue_op(fqalu_pkg::OP_MUL, -1, 1);
      queue_op(fqalu_pkg::OP_DIV, 256, 0);
      queue_op(fqalu_pkg::OP_DIV, 32'sh80000000, -1);
      queue_op(fqalu_pkg::OP_DIV, -256, 768);
      queue_op(fqalu_pkg::OP_DIV, 32'sh7fffffff, 1);
      queue_op(fqalu_pkg::OP_INC, 32'sh7fffffff, 0);
      queue_op(fqalu_pkg::OP_DEC, 32'sh80000000, 0);
      queue_op(fqalu_pkg::OP_CMP, 5, 5);
      queue_op(fqalu_pkg::OP_CMP, -1, 1);
      queue_op(fqalu_pkg::OP_MIN, 32'sh80000000, 32'sh7fffffff);
      queue_op(fqalu_pkg::OP_MAX, -1, -2);
      queue_op(fqalu_pkg::OP_MIN, 7, 7);
      queue_op(fqalu_pkg::OP_TO_INT, -1, 0);
      queue_op(fqalu_pkg::OP_TO_INT, -257, 0);
      queue_op(fqalu_pkg::OP_TO_INT, 32'sh7fffffff, 0);
      queue_op(fqalu_pkg::OP_FROM_INT, 32'sh80ffffff, 0);
      queue_op(fqalu_pkg::OP_FROM_INT, -3, 0);
      queue_op(OP_SPARE_MAX, -1, 0);

      // Random traffic. The first random transaction and one in the middle
      // wait for an empty pipe.
      for (int i = 0; i < N_RANDOM; i++) begin
         if ($urandom_range(0, 15) == 0)
            t.op = 4'($urandom_range(fqalu_pkg::OP_FROM_INT + 1, OP_SPARE_MAX));
         else
            t.op = 4'($urandom_range(fqalu_pkg::OP_ADD, fqalu_pkg::OP_FROM_INT));
         t.a = pick_operand();
         t.b = ($urandom_range(0, 7) == 0) ? t.a : pick_operand();
         if (t.op == fqalu_pkg::OP_DIV && $urandom_range(0, 9) == 0) t.b = 0;
         t.drain = (i == 0 || i == N_RANDOM / 2);
         ops_pending.push_back(t);
      end
      n_total = ops_pending.size();

      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      do @(negedge clock);
      while (n_sent != n_total || results_due.size() != 0);
      // Extra quiet time so a stray response would be flagged.
      repeat (2 * LATENCY) @(negedge clock);

      $display("Sent %0d transactions (%0d divide by zero, %0d spare opcode), checked %0d",
               n_sent, n_dz, n_spare, n_checked);
      $display("responses; long output hold exercised: %0d", hold_done);
      if (n_errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
design/fqalu_pkg.sv
design/fqalu_front.sv
design/fqalu_div_step.sv
design/fqalu_back.sv
design/fixed_point_q24_8_alu.sv
design/fqalu_checker.sv
dv/tb_fixed_point_q24_8_alu.sv
